// ===== rtl/core/ssc_pkg.sv =====
// Shared constants and widths for the spaced selection counter.
package ssc_pkg;
  localparam int N_WIDTH = 16;
  localparam int K_WIDTH = 16;
  localparam int MOD_W   = 23;
  localparam int TOP_W   = ((N_WIDTH > K_WIDTH) ? N_WIDTH : K_WIDTH) + 1;
  localparam int BIT_W   = $clog2(MOD_W + 1);
  localparam logic [MOD_W-1:0] PRIME   = MOD_W'(5000011);
  localparam logic [MOD_W-1:0] INV_EXP = MOD_W'(5000009);
  localparam logic [MOD_W-1:0] ONE     = MOD_W'(1);
endpackage

// ===== rtl/core/ssc_in_if.sv =====
// Input channel carrying row length and gap.
interface ssc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_length;
  logic [15:0] min_gap;
  modport source (output valid, row_length, min_gap, input ready);
  modport sink (input valid, row_length, min_gap, output ready);
endinterface

// ===== rtl/core/ssc_out_if.sv =====
// Output channel carrying the count modulo the prime.
interface ssc_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] count_mod;
  modport source (output valid, count_mod, input ready);
  modport sink (input valid, count_mod, output ready);
endinterface

// ===== rtl/core/ssc_mulmod.sv =====
// Bit-serial modular multiplier, one bit of the multiplier per cycle.
module ssc_mulmod (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [ssc_pkg::MOD_W-1:0] a,
  input  logic [ssc_pkg::MOD_W-1:0] b,
  output logic                    done,
  output logic [ssc_pkg::MOD_W-1:0] res
);
  import ssc_pkg::*;

  logic [MOD_W-1:0] a_sh;
  logic [MOD_W-1:0] b_hold;
  logic [BIT_W-1:0] cnt;
  logic             busy;
  logic [MOD_W:0]   dbl, dbl_red, add, add_red;

  // Double, reduce, add the selected multiplicand, reduce
  always_comb begin
    dbl     = {res, 1'b0};
    dbl_red = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
    add     = dbl_red + (a_sh[MOD_W-1] ? {1'b0, b_hold} : '0);
    add_red = (add >= {1'b0, PRIME}) ? add - {1'b0, PRIME} : add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (go) begin
      busy   <= 1'b1;
      a_sh   <= a;
      b_hold <= b;
      res    <= '0;
      cnt    <= '0;
      done   <= 1'b0;
    end else if (busy) begin
      res  <= add_red[MOD_W-1:0];
      a_sh <= {a_sh[MOD_W-2:0], 1'b0};
      cnt  <= cnt + 1'b1;
      done <= (cnt == BIT_W'(MOD_W - 1));
      if (cnt == BIT_W'(MOD_W - 1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end
endmodule

// ===== rtl/core/spaced_selection_count_mod_prime_top.sv =====
// Spaced selection counter: sums C(n-(x-1)k, x) mod 5000011 with a shared multiplier.
// Work: every modular product runs on the one bit-serial multiplier; a term
//   needs 2*min(x,top-x) falling-product steps, 23 squarings, 10 multiplies for p-2 and one
//   final product.
// Throughput: one item at a time; the next transfer is taken once the result
//   is loaded into the output register, which may still wait to be taken.
// Reset: synchronous, clears sequencer and output valid; no state between items.
module spaced_selection_count_mod_prime_top (
  input logic clk,
  input logic rst,
  ssc_in_if.sink    req,
  ssc_out_if.source rsp
);
  import ssc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TERM = 4'd1;
  localparam logic [3:0] S_LOOP = 4'd2;
  localparam logic [3:0] S_NUMW = 4'd3;
  localparam logic [3:0] S_DENW = 4'd4;
  localparam logic [3:0] S_SQW  = 4'd5;
  localparam logic [3:0] S_EMW  = 4'd6;
  localparam logic [3:0] S_FINW = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state;
  logic [TOP_W-1:0] kgap, x, top, pick, i;
  logic [MOD_W-1:0] num, den, eacc, sum;
  logic [BIT_W-1:0] ebit;
  logic             mul_go, mul_done;
  logic [MOD_W-1:0] mul_a, mul_b, mul_res;
  logic [MOD_W:0]   sum_add;
  logic [TOP_W-1:0] top_m_x;

  ssc_mulmod u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  assign req.ready = (state == S_IDLE);
  assign sum_add   = {1'b0, sum} + {1'b0, mul_res};
  assign top_m_x   = top - x;

  // Sequence terms, falling products, inverse exponentiation and the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      mul_go    <= 1'b0;
    end else begin
      // Drop valid after the transfer unless a new result is loaded now
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          mul_go <= 1'b0;
          if (req.valid) begin
            kgap  <= TOP_W'(req.min_gap);
            x     <= '0;
            top   <= TOP_W'(req.row_length[N_WIDTH-1:0]) + TOP_W'(req.min_gap);
            sum   <= '0;
            state <= S_TERM;
          end
        end
        S_TERM: begin
          mul_go <= 1'b0;
          pick   <= (x < top_m_x) ? x : top_m_x;
          i      <= TOP_W'(1);
          num    <= ONE;
          den    <= ONE;
          state  <= S_LOOP;
        end
        S_LOOP: begin
          mul_go <= 1'b1;
          if (i > pick) begin
            mul_a <= ONE;
            mul_b <= ONE;
            eacc  <= ONE;
            ebit  <= BIT_W'(MOD_W - 1);
            state <= S_SQW;
          end else begin
            mul_a <= num;
            mul_b <= MOD_W'(top - i + TOP_W'(1));
            state <= S_NUMW;
          end
        end
        S_NUMW: begin
          mul_go <= mul_done;
          if (mul_done) begin
            num    <= mul_res;
            mul_a  <= den;
            mul_b  <= MOD_W'(i);
            state  <= S_DENW;
          end
        end
        S_DENW: begin
          mul_go <= 1'b0;
          if (mul_done) begin
            den   <= mul_res;
            i     <= i + TOP_W'(1);
            state <= S_LOOP;
          end
        end
        S_SQW, S_EMW: begin
          mul_go <= mul_done;
          if (mul_done) begin
            eacc   <= mul_res;
            if (state == S_SQW && INV_EXP[ebit[$clog2(MOD_W)-1:0]]) begin
              mul_a <= mul_res;
              mul_b <= den;
              state <= S_EMW;
            end else if (ebit == '0) begin
              mul_a <= num;
              mul_b <= mul_res;
              state <= S_FINW;
            end else begin
              ebit  <= ebit - 1'b1;
              mul_a <= mul_res;
              mul_b <= mul_res;
              state <= S_SQW;
            end
          end
        end
        S_FINW: begin
          mul_go <= 1'b0;
          if (mul_done) begin
            sum <= (sum_add >= {1'b0, PRIME}) ? MOD_W'(sum_add - {1'b0, PRIME})
                                              : sum_add[MOD_W-1:0];
            // Next term exists only while x+1 <= top-k
            if (top < kgap + x + TOP_W'(1)) begin
              state <= S_DONE;
            end else begin
              top   <= top - kgap;
              x     <= x + TOP_W'(1);
              state <= S_TERM;
            end
          end
        end
        S_DONE: begin
          mul_go <= 1'b0;
          if (!rsp.valid || rsp.ready) begin
            rsp.count_mod <= sum;
            rsp.valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          mul_go <= 1'b0;
          state  <= S_IDLE;
        end
      endcase
    end
  end

  // A finished count is always reduced
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.count_mod < PRIME)
    else $error("count out of range");

  // Results are loaded only from the finish state
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside finish");

  // Multiplier completions arrive only while the sequencer waits on one
  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_NUMW || state == S_DENW || state == S_SQW ||
                  state == S_EMW || state == S_FINW))
    else $error("unexpected multiplier completion");
endmodule
